// ===== hdl/cksx_pkg.sv =====
// Shared types and constants for the colour-key span extractor.
// Holds the pixel and span item structs, register indexes and sizing defaults.
// No dependencies.
`timescale 1ns / 1ps

package cksx_pkg;

	// Default window limits, handed to the top level as parameter defaults.
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Depth of the queue between classifier and span builder (power of two).
	localparam int QUEUE_DEPTH = 4;

	// Fixed widths of the configuration and result fields.
	localparam int KEY_W      = 24;
	localparam int SIZE_W     = 13;
	localparam int CFG_DATA_W = 24;
	localparam int SPAN_ROW_W = 12;
	localparam int SPAN_COL_W = 12;
	localparam int SPAN_END_W = 13;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_KEY_COLOR     = 2'd0,
		REG_WINDOW_WIDTH  = 2'd1,
		REG_WINDOW_HEIGHT = 2'd2
	} cfg_reg_t;

	// One input item.
	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} pixel_t;

	// One result item.
	typedef struct packed {
		logic                  span_valid;
		logic [SPAN_ROW_W-1:0] span_row;
		logic [SPAN_COL_W-1:0] span_start;
		logic [SPAN_END_W-1:0] span_end;
		logic                  frame_last;
	} span_t;

	// Classification of one pixel, passed from the front to the back.
	typedef struct packed {
		logic transparent;
		logic row_end;
		logic frame_end;
	} px_flags_t;

endpackage

// ===== hdl/cksx_front.sv =====
// Front end: configuration registers, raster position counters and key compare.
// Classifies each accepted pixel for the span builder. Depends on cksx_pkg.
`timescale 1ns / 1ps

module cksx_front #(
	parameter int MAX_WIDTH  = cksx_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cksx_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [1:0]                              cfg_index,
	input  logic [cksx_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    accept,
	input  cksx_pkg::pixel_t                        pixel,
	output cksx_pkg::px_flags_t                     flags,
	output logic [$clog2(MAX_WIDTH)-1:0]            col,
	output logic [$clog2(MAX_HEIGHT)-1:0]           row
);
	import cksx_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int LWW = CW + 1;
	localparam int LWH = RW + 1;

	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [LWW-1:0]    width_lim;
	logic [LWH-1:0]    height_lim;
	logic              row_end;
	logic              frame_end;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			width_q  <= SIZE_W'(1);
			height_q <= SIZE_W'(1);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_COLOR:     key_q    <= cfg_data[KEY_W-1:0];
				REG_WINDOW_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_WINDOW_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Window size with zero read as one and large values saturated.
	always_comb begin
		if (width_q == '0) begin
			width_lim = LWW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			width_lim = LWW'(MAX_WIDTH);
		end else begin
			width_lim = LWW'(width_q);
		end
		if (height_q == '0) begin
			height_lim = LWH'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			height_lim = LWH'(MAX_HEIGHT);
		end else begin
			height_lim = LWH'(height_q);
		end
	end

	// A position at or past the last column or row ends it, so a mid-frame resize is safe.
	assign row_end   = {1'b0, col_q} >= (width_lim - 1'b1);
	assign frame_end = row_end && ({1'b0, row_q} >= (height_lim - 1'b1));

	// Raster position advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Key colour compare on all three channels.
	assign flags.transparent = (pixel.pixel_red   == key_q[7:0])
	                        && (pixel.pixel_green == key_q[15:8])
	                        && (pixel.pixel_blue  == key_q[23:16]);
	assign flags.row_end   = row_end;
	assign flags.frame_end = frame_end;
	assign col = col_q;
	assign row = row_q;

endmodule

// ===== hdl/cksx_queue.sv =====
// Short register queue that decouples the classifier from the span builder.
// Generic data width. Depends on cksx_pkg for its depth.
`timescale 1ns / 1ps

module cksx_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic              rd_valid,
	output logic [DATA_W-1:0] rd_data
);
	import cksx_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       count_q;

	// Storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full     = count_q == (PW+1)'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];

	// Occupancy never goes beyond the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(QUEUE_DEPTH))
		else $error("queue occupancy beyond depth");

endmodule

// ===== hdl/cksx_back.sv =====
// Back end: tracks the open run and builds span items into the output register.
// Consumes classified pixels from the queue. Depends on cksx_pkg.
`timescale 1ns / 1ps

module cksx_back #(
	parameter int MAX_WIDTH  = cksx_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cksx_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_take,
	input  cksx_pkg::px_flags_t           flags,
	input  logic [$clog2(MAX_WIDTH)-1:0]  col,
	input  logic [$clog2(MAX_HEIGHT)-1:0] row,
	output logic                          empty,
	input  logic                          pop,
	output cksx_pkg::span_t               span
);
	import cksx_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic          run_open_q;
	logic [CW-1:0] run_start_q;
	logic          out_valid_q;
	span_t         out_q;
	logic          take;
	logic          emit;
	logic          have_span;
	logic          run_open_d;
	logic [CW-1:0] run_start_d;
	logic [CW:0]   col_ext;
	logic [CW:0]   end_col;
	span_t         result;

	// A queued item is taken whenever the output register is free or being emptied.
	assign take    = in_valid && (!out_valid_q || pop);
	assign in_take = take;
	assign col_ext = {1'b0, col};

	// Run tracking: a transparent pixel closes an open run, the row end closes any run.
	always_comb begin
		have_span   = 1'b0;
		run_open_d  = run_open_q;
		run_start_d = run_start_q;
		end_col     = col_ext;
		if (flags.transparent) begin
			have_span  = run_open_q;
			run_open_d = 1'b0;
		end else begin
			if (!run_open_q) begin
				run_start_d = col;
			end
			if (flags.row_end) begin
				have_span  = 1'b1;
				end_col    = col_ext + 1'b1;
				run_open_d = 1'b0;
			end else begin
				run_open_d = 1'b1;
			end
		end
	end

	// Result item; a frame end without a span carries zero fields.
	always_comb begin
		result = '0;
		if (have_span) begin
			result.span_valid = 1'b1;
			result.span_row   = SPAN_ROW_W'(row);
			result.span_start = SPAN_COL_W'(run_start_d);
			result.span_end   = SPAN_END_W'(end_col);
		end
		result.frame_last = flags.frame_end;
	end
	assign emit = have_span || flags.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q  <= 1'b0;
			run_start_q <= '0;
		end else if (take) begin
			run_open_q  <= run_open_d;
			run_start_q <= run_start_d;
		end
	end

	// Output register holds one result item until it is popped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_q <= result;
		end
	end

	assign empty = !out_valid_q;
	assign span  = out_q;

	// The frame's final pixel always shows up as a last-marked result.
	a_frame_end_out: assert property (@(posedge clk) disable iff (!arst_n)
		take && flags.frame_end |=> out_valid_q && out_q.frame_last)
		else $error("frame end produced no last result");

	// A result without a span is only ever the frame-end marker.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.span_valid |-> out_q.frame_last)
		else $error("spanless result not marked last");

	// No run stays open across a row boundary.
	a_run_closed: assert property (@(posedge clk) disable iff (!arst_n)
		take && flags.row_end |=> !run_open_q)
		else $error("run left open past row end");

	// A pending result is not overwritten while it waits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_q))
		else $error("pending result lost");

endmodule

// ===== hdl/color_key_span_extractor_core.sv =====
// Top level of the colour-key span extractor: classifier, queue and span builder.
// Depends on cksx_pkg, cksx_front, cksx_queue and cksx_back.
//
//  Channel   Handshake            Payload
//  pixel     push / full          pixel (pixel_t)
//  span      empty / pop          span (span_t)
//  config    cfg_write            cfg_index, cfg_data
//
// One pixel item is accepted per cycle while the queue is not full; the
// classified pixel is queued first, then its result enters the output register.
// The span builder takes one queued item per cycle while the output register is
// free or popped; that register and the four-entry queue absorb result-side stalls.
// Reset clears positions, the open run, the queue and the output register;
// no clearing pass is needed.
`timescale 1ns / 1ps

module color_key_span_extractor_core #(
	parameter int MAX_WIDTH  = cksx_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cksx_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  cksx_pkg::pixel_t                pixel,
	output logic                            empty,
	input  logic                            pop,
	output cksx_pkg::span_t                 span,
	input  logic                            cfg_write,
	input  logic [1:0]                      cfg_index,
	input  logic [cksx_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cksx_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int QW = $bits(px_flags_t) + CW + RW;

	logic          accept;
	px_flags_t     fr_flags;
	logic [CW-1:0] fr_col;
	logic [RW-1:0] fr_row;
	logic          q_full;
	logic          q_valid;
	logic          q_take;
	logic [QW-1:0] q_rd_data;
	px_flags_t     bk_flags;
	logic [CW-1:0] bk_col;
	logic [RW-1:0] bk_row;

	assign accept = push && !q_full;
	assign full   = q_full;

	cksx_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.pixel     (pixel),
		.flags     (fr_flags),
		.col       (fr_col),
		.row       (fr_row)
	);

	cksx_queue #(
		.DATA_W (QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_data  ({fr_flags, fr_col, fr_row}),
		.full     (q_full),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_data  (q_rd_data)
	);

	assign {bk_flags, bk_col, bk_row} = q_rd_data;

	cksx_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_take  (q_take),
		.flags    (bk_flags),
		.col      (bk_col),
		.row      (bk_row),
		.empty    (empty),
		.pop      (pop),
		.span     (span)
	);

endmodule
